/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

/* rtl/twep_pkg.sv */
// Shared constants, word types and controller/datapath interface structs.
// Depends on nothing.
package twep_pkg;

    // largest sum one group may reach
    localparam int PART_MAX  = 255;
    localparam int ROW_W     = PART_MAX + 1;
    localparam int ADDR_W    = $clog2(PART_MAX + 1);
    localparam int TOTAL_CAP = 3 * PART_MAX;
    localparam int TOT_W     = $clog2(TOTAL_CAP + 1);
    localparam int VAL_W     = 8;
    localparam int SUM_W     = ((TOT_W > VAL_W) ? TOT_W : VAL_W) + 1;

    // v / 3 for 8-bit v as (v * 171) >> 9
    localparam int DIV3_MUL   = 171;
    localparam int DIV3_SHIFT = 9;

    // grid row after reset: row 0 holds only the origin
    localparam logic [ROW_W-1:0] ORIGIN_ROW = ROW_W'(1);

    typedef struct packed {
        logic [VAL_W-1:0] item_value;
        logic             last_item;
    } t_in_word;

    typedef struct packed {
        logic can_split;
        logic total_overflow;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic load_item;   // take the accepted word, update totals
        logic rd;          // read grid rows for the current sweep row
        logic chk_rd;      // read the row of total/3
        logic out_load;    // register the answer and restart the set
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_skip;     // incoming value leaves the grid unchanged
        logic in_last;     // incoming word closes the set
        logic last;        // held word closes the set
        logic row_zero;    // sweep is at row 0
    } t_status;

endpackage

/* rtl/twep_ctrl.sv */
// Controller: sequences the row sweep, the final check and the output word.
// Depends on twep_pkg.
module twep_ctrl
    import twep_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SWEEP = 5'b00010,
        S_DRAIN = 5'b00100,
        S_CHKRD = 5'b01000,
        S_CHECK = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_acc;
    logic   out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.load_item = in_acc;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!i_st.in_skip) begin
                        n_state = S_SWEEP;
                    end else if (i_st.in_last) begin
                        n_state = S_CHKRD;
                    end
                end
            end
            S_SWEEP: begin
                o_cmd.rd = 1'b1;
                if (i_st.row_zero) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = i_st.last ? S_CHKRD : S_IDLE;
            end
            S_CHKRD: begin
                o_cmd.chk_rd = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid: set on load, dropped once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/twep_datapath.sv */
// Datapath: reachability grid memory, row update, running total and answer.
// Depends on twep_pkg.
module twep_datapath
    import twep_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_word,
    input  t_cmd      i_cmd,
    output t_status   o_st,
    output t_out_word o_out_word
);

    // grid memory, one row per sum of group one
    logic [ROW_W-1:0]  mem [ROW_W];
    logic [ROW_W-1:0]  r_vld;

    // held item
    logic [VAL_W-1:0]  r_item_v;
    logic              r_last;
    logic [ADDR_W-1:0] r_row;

    // totals: saturating sum plus quotient and remainder by three
    logic [TOT_W-1:0]  r_total;
    logic [ADDR_W-1:0] r_q;
    logic [1:0]        r_rem;
    logic              r_ovf;

    // read stage
    logic [ROW_W-1:0]  r_rd_a, r_rd_b;
    logic              r_vld_a, r_vld_b;
    logic              r_b_use, r_b_org;
    logic [ADDR_W-1:0] r_rda_addr;
    logic              r_wr_pend;

    t_out_word         r_out_word;

    logic [ADDR_W-1:0] v_a;
    logic [ADDR_W-1:0] addr_a, addr_b;
    logic              b_use;
    logic [ROW_W-1:0]  a_eff, b_eff, new_row;

    logic [VAL_W-1:0]  in_v;
    logic [15:0]       div_prod;
    logic [VAL_W-1:0]  qv;
    logic [9:0]        three_qv;
    logic [1:0]        rv;
    logic [SUM_W-1:0]  sum;
    logic              sum_ovf;
    logic [2:0]        rsum;
    logic              carry;

    // status
    assign in_v          = i_in_word.item_value;
    assign o_st.in_skip  = (in_v == '0) || (int'(in_v) > PART_MAX);
    assign o_st.in_last  = i_in_word.last_item;
    assign o_st.last     = r_last;
    assign o_st.row_zero = (r_row == '0);

    // read addresses: row i and row i - v, or row total/3 for the check
    assign v_a    = ADDR_W'(r_item_v);
    assign b_use  = (r_row >= v_a);
    assign addr_b = r_row - v_a;
    assign addr_a = i_cmd.chk_rd ? r_q : r_row;

    // unwritten rows read as their reset value
    assign a_eff = r_vld_a ? r_rd_a : ((r_rda_addr == '0) ? ORIGIN_ROW : '0);
    assign b_eff = r_vld_b ? r_rd_b : (r_b_org ? ORIGIN_ROW : '0);

    // row update: keep, shift along group two, take row i - v for group one
    assign new_row = a_eff | (a_eff << r_item_v) | (r_b_use ? b_eff : '0);

    // incoming value split by three without a divider
    assign div_prod = 16'(in_v) * 16'(DIV3_MUL);
    assign qv       = VAL_W'(div_prod >> DIV3_SHIFT);
    assign three_qv = 10'(qv) * 10'd3;
    assign rv       = 2'(10'(in_v) - three_qv);
    assign rsum     = 3'(r_rem) + 3'(rv);
    assign carry    = (rsum >= 3'd3);

    assign sum     = SUM_W'(r_total) + SUM_W'(in_v);
    assign sum_ovf = (sum > SUM_W'(TOTAL_CAP));

    // item and sweep counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item_v <= in_v;
            r_last   <= i_in_word.last_item;
            r_row    <= ADDR_W'(PART_MAX);
        end else if (i_cmd.rd) begin
            r_row    <= r_row - ADDR_W'(1);
        end
    end

    // totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.out_load) begin
            r_total <= '0;
            r_q     <= '0;
            r_rem   <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.load_item) begin
            if (sum_ovf) begin
                r_total <= TOT_W'(TOTAL_CAP);
                r_ovf   <= 1'b1;
            end else begin
                r_total <= TOT_W'(sum);
                r_q     <= r_q + ADDR_W'(qv) + ADDR_W'(carry);
                r_rem   <= carry ? 2'(rsum - 3'd3) : 2'(rsum);
            end
        end
    end

    // grid memory: two read ports, one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd || i_cmd.chk_rd) begin
            r_rd_a <= mem[addr_a];
        end
        if (i_cmd.rd) begin
            r_rd_b <= mem[addr_b];
        end
        if (r_wr_pend) begin
            mem[r_rda_addr] <= new_row;
        end
    end

    // valid bits and read-stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= i_cmd.rd;
            if (i_cmd.out_load) begin
                r_vld <= '0;
            end else if (r_wr_pend) begin
                r_vld[r_rda_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd || i_cmd.chk_rd) begin
            r_vld_a    <= r_vld[addr_a];
            r_rda_addr <= addr_a;
        end
        if (i_cmd.rd) begin
            r_vld_b <= r_vld[addr_b];
            r_b_use <= b_use;
            r_b_org <= (addr_b == '0);
        end
    end

    // answer register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_word.can_split      <= !r_ovf && (r_rem == 2'd0) && a_eff[r_q];
            r_out_word.total_overflow <= r_ovf;
        end
    end

    assign o_out_word = r_out_word;

endmodule

/* rtl/three_way_equal_partition_top.sv */
// Top level of the three-way equal-sum partition checker.
// Depends on twep_pkg, twep_ctrl, twep_datapath and assert_macros.svh.
//
// Input channel: one word per item (item_value, last_item), valid/stall.
// Output channel: one word (can_split, total_overflow) per set, sent
// after the word marked last_item; no word is sent for other items.
// A grid of PART_MAX+1 rows records which (group one, group two) sums are
// reachable; each item with a value from 1 to PART_MAX sweeps every row
// once, one row per cycle through a two-read-port grid memory.
// A value that updates the grid holds the input for its sweep; a zero value
// or one above PART_MAX is taken without a sweep and leaves the grid unchanged.
// After the word marked last, the row of total/3 is read, then the answer is
// registered once the output register is free; o_out_valid rises with it.
// The input is stalled while an item is being processed.
// A finished answer waits in the output register while the receiver
// stalls; new items are still accepted, and a further answer waits in the
// controller until the register frees.
// Reset (synchronous, active low) clears the row valid bits at once, so
// the grid reads as holding only the origin; totals return to zero.
`include "assert_macros.svh"
module three_way_equal_partition_top
    import twep_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_cmd    cmd;
    t_status st;

    twep_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    twep_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (cmd),
        .o_st       (st),
        .o_out_word (o_out_word)
    );

    // the sweep read and the check read never share the A port
    `ASSERT_NEVER(a_rd_excl, i_clk, i_rst_n, cmd.rd && cmd.chk_rd)
    // an answer is never loaded over one the receiver still holds off
    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, cmd.out_load && o_out_valid && i_out_stall)
    // after an answer the block is ready for the next set
    `ASSERT_CLK(a_ready_after_out, i_clk, i_rst_n, cmd.out_load |=> !o_in_stall)
    // a new item is only taken while no sweep is running
    `ASSERT_NEVER(a_load_in_sweep, i_clk, i_rst_n, cmd.load_item && cmd.rd)

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for three_way_equal_partition_top: a directed and random set stream
// checked word by word against a bit-level reachability-grid predictor.
// Depends on twep_pkg and the three_way_equal_partition_top RTL.
module tb_top;
    import twep_pkg::*;

    localparam int ITEM_TARGET  = 1350;
    localparam int DRAIN_CYCLES = ROW_W + 64;
    // worst case per item: full sweep, longest send gap, longest receive stall
    localparam int WORST_ITEM   = ROW_W + 3 + 40 + 60;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;

    // predictor state: reachable (group one, group two) sums and set total
    logic [ROW_W-1:0] reach_rows [0:ROW_W-1];
    logic [TOT_W-1:0] set_total;
    logic             set_overflowed;

    t_in_word  items_to_send [$];
    t_out_word answers_due [$];

    int unsigned items_total    = 0;
    int unsigned sets_total     = 0;
    int unsigned items_accepted = 0;
    int unsigned answers_seen   = 0;
    int unsigned splits_seen    = 0;
    int unsigned overflow_sets  = 0;
    int unsigned mismatches     = 0;
    int unsigned cycle_cnt      = 0;
    int unsigned cycle_limit    = 0;
    int unsigned send_gap       = 0;
    int unsigned stall_left     = 0;
    int unsigned free_left      = 0;

    three_way_equal_partition_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // back to the empty set: only the origin is reachable
    function automatic void restart_set();
        for (int i = 0; i < ROW_W; i++) reach_rows[i] = '0;
        reach_rows[0]  = ORIGIN_ROW;
        set_total      = '0;
        set_overflowed = 1'b0;
    endfunction

    // one item: either axis shift, or stays put (group three)
    function automatic bit take_item(input t_in_word w, output t_out_word ans);
        int unsigned v;
        int unsigned sum;
        int unsigned third;
        logic [ROW_W-1:0] row;
        v   = w.item_value;
        sum = set_total + v;
        ans = '0;
        if (sum > TOTAL_CAP) begin
            set_total      = TOT_W'(TOTAL_CAP);
            set_overflowed = 1'b1;
        end else begin
            set_total = TOT_W'(sum);
        end
        // descending rows so row i-v is still the old one when row i is built
        if (v != 0 && v <= PART_MAX) begin
            for (int i = PART_MAX; i >= 0; i--) begin
                row = reach_rows[i] | (reach_rows[i] << v);
                if (i >= int'(v)) row = row | reach_rows[i - v];
                reach_rows[i] = row;
            end
        end
        if (!w.last_item) return 1'b0;
        ans.total_overflow = set_overflowed;
        if (!set_overflowed && (set_total % 3) == 0) begin
            third         = set_total / 3;
            ans.can_split = reach_rows[third][third];
        end
        restart_set();
        return 1'b1;
    endfunction

    task automatic queue_set(input int vals[$]);
        t_in_word w;
        foreach (vals[k]) begin
            w.item_value = VAL_W'(vals[k]);
            w.last_item  = (k == vals.size() - 1);
            items_to_send.push_back(w);
            items_total++;
        end
        sets_total++;
    endtask

    // driver: present queued words, random gaps between them
    always @(posedge clk) begin
        logic        nxt_valid;
        t_in_word    nxt_word;
        int unsigned nxt_gap;
        int unsigned r;
        t_out_word   ans;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_word  <= '0;
            send_gap <= 0;
        end else begin
            nxt_valid = in_valid;
            nxt_word  = in_word;
            nxt_gap   = send_gap;
            if (in_valid && !in_stall) begin
                items_accepted++;
                if (take_item(in_word, ans)) answers_due.push_back(ans);
                nxt_valid = 1'b0;
                r = $urandom_range(0, 99);
                if (r < 60)      nxt_gap = 0;
                else if (r < 92) nxt_gap = $urandom_range(1, 3);
                else             nxt_gap = $urandom_range(10, 40);
            end
            if (!nxt_valid) begin
                if (nxt_gap != 0) begin
                    nxt_gap--;
                end else if (items_to_send.size() != 0) begin
                    nxt_word  = items_to_send.pop_front();
                    nxt_valid = 1'b1;
                end
            end
            in_valid <= nxt_valid;
            in_word  <= nxt_word;
            send_gap <= nxt_gap;
        end
    end

    // monitor: check answers in order, drive receiver stall in runs
    always @(posedge clk) begin
        t_out_word   want;
        logic        nxt_stall;
        int unsigned r;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            free_left  <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                answers_seen++;
                if (out_word.can_split)      splits_seen++;
                if (out_word.total_overflow) overflow_sets++;
                if (answers_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected answer word can_split=%b total_overflow=%b",
                                 $realtime, out_word.can_split, out_word.total_overflow);
                    mismatches++;
                end else begin
                    want = answers_due.pop_front();
                    if (out_word.can_split !== want.can_split ||
                        out_word.total_overflow !== want.total_overflow) begin
                        if (mismatches < 10)
                            $display("%0t: answer %0d mismatch: exp can_split=%b ovf=%b, got %b %b",
                                     $realtime, answers_seen, want.can_split,
                                     want.total_overflow, out_word.can_split,
                                     out_word.total_overflow);
                        mismatches++;
                    end
                end
            end
            if (stall_left != 0) begin
                nxt_stall = 1'b1;
                stall_left <= stall_left - 1;
            end else if (free_left != 0) begin
                nxt_stall = 1'b0;
                free_left <= free_left - 1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    nxt_stall = 1'b0;
                    free_left <= $urandom_range(1, 30);
                end else if (r < 85) begin
                    nxt_stall = 1'b1;
                    stall_left <= $urandom_range(0, 2);
                end else begin
                    nxt_stall = 1'b1;
                    stall_left <= $urandom_range(9, 59);
                end
            end
            out_stall <= nxt_stall;
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_limit != 0 && cycle_cnt >= cycle_limit) begin
            $display("timeout after %0d cycles, %0d answers still due",
                     cycle_cnt, answers_due.size());
            $display("FAIL");
            $finish;
        end
    end

    // stimulus
    initial begin
        int          set_vals [$];
        int unsigned kind;
        int unsigned target;
        int unsigned rem;
        int unsigned part;
        int unsigned idx;
        int unsigned d;
        int          tmp;
        restart_set();

        // directed sets
        queue_set('{0});                        // all-zero set
        queue_set('{1, 1, 1});                  // smallest nontrivial split
        queue_set('{1, 2});                     // total divides by 3, not reachable
        queue_set('{255, 255, 255});            // exactly at the total cap
        queue_set('{255, 255, 255, 1});         // one past the cap
        queue_set('{200, 200, 200, 200});       // saturates on the last item
        queue_set('{4, 2, 2, 4});               // clean set right after overflow
        queue_set('{170, 85, 85, 170, 0});      // shifted pairs leave the grid
        queue_set('{0, 0, 3});                  // lone value, no split

        // random sets: mostly equal-sum groups, some perturbed, some noise
        while (items_total < ITEM_TARGET) begin
            set_vals.delete();
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                target = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 40)
                                                   : $urandom_range(41, 255);
                for (int g = 0; g < 3; g++) begin
                    rem = target;
                    while (rem != 0) begin
                        part = $urandom_range(1, rem);
                        set_vals.push_back(part);
                        rem -= part;
                    end
                end
                if ($urandom_range(0, 3) == 0) set_vals.push_back(0);
                for (int k = set_vals.size() - 1; k > 0; k--) begin
                    idx           = $urandom_range(0, k);
                    tmp           = set_vals[k];
                    set_vals[k]   = set_vals[idx];
                    set_vals[idx] = tmp;
                end
                // broken set: nudge one value off balance
                if (kind >= 55 && set_vals.size() != 0) begin
                    idx = $urandom_range(0, set_vals.size() - 1);
                    d   = $urandom_range(1, 3);
                    if (set_vals[idx] >= d && $urandom_range(0, 1))
                        set_vals[idx] = set_vals[idx] - d;
                    else
                        set_vals[idx] = (set_vals[idx] + d > 255) ? 255 : set_vals[idx] + d;
                end
            end else begin
                repeat ($urandom_range(1, 6)) set_vals.push_back($urandom_range(0, 255));
            end
            if (set_vals.size() == 0) set_vals.push_back(0);
            queue_set(set_vals);
        end
        cycle_limit = items_total * WORST_ITEM * 3 + 10000;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (items_accepted < items_total || answers_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items in %0d sets, %0d answers checked (%0d splittable, %0d overflowed)",
                 items_total, sets_total, answers_seen, splits_seen, overflow_sets);
        $display("%0d mismatches in %0d cycles", mismatches, cycle_cnt);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* three_way_equal_partition_top.f */
+incdir+rtl
rtl/twep_pkg.sv
rtl/twep_ctrl.sv
rtl/twep_datapath.sv
rtl/three_way_equal_partition_top.sv
dv/tb_top.sv
